### hw/rtl/bvcf_pkg.sv
// shared constants and codes for the bimanual virtual coupling force block
// no dependencies; used by the top level and its port checker

package bvcf_pkg;

   localparam int POS_WIDTH_DEF  = 32;
   localparam int TIME_WIDTH_DEF = 48;

   localparam int ACTION_W = 3;
   localparam int STATUS_W = 2;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int FORCE_W = 32;

   typedef enum logic [ACTION_W-1:0] {
      ACT_MASTER_LEFT  = 3'd0,
      ACT_MASTER_RIGHT = 3'd1,
      ACT_SLAVE_LEFT   = 3'd2,
      ACT_SLAVE_RIGHT  = 3'd3,
      ACT_TICK         = 3'd4
   } action_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK      = 2'd0,
      STAT_MISSING = 2'd1,
      STAT_STALE   = 2'd2,
      STAT_DEGEN   = 2'd3
   } status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_STIFFNESS = 3'd0,
      CSR_DEADBAND  = 3'd1,
      CSR_LIMIT     = 3'd2,
      CSR_ALPHA     = 3'd3,
      CSR_STALE     = 3'd4
   } csr_index_type;

   localparam logic [31:0] STIFFNESS_RST = 32'd5242880;
   localparam logic [30:0] DEADBAND_RST  = 31'd2097;
   localparam logic [30:0] LIMIT_RST     = 31'd2621440;
   localparam logic [16:0] ALPHA_RST     = 17'd6554;
   localparam logic [31:0] STALE_RST     = 32'd200000;
   localparam logic [16:0] ALPHA_ONE     = 17'd65536;

endpackage

### hw/rtl/bimanual_virtual_coupling_force.sv
// top level of the bimanual virtual coupling force block
// depends on bvcf_pkg; one shared multiplier and one shared subtract unit
//
// usage:
//   req_* channel (valid/stall) carries one word per pose update or tick.
//   a pose word (action 0..3) is stored, gives no result and leaves the block
//   ready for the next word. unknown actions are dropped.
//   a tick word (action 4) gives exactly one rsp_* word: the coupling force
//   for the left arm, its negation for the right arm, and a status code.
//   a tick with a missing or stale pose answers without the force
//   computation, whose time is set by the shared subtract unit, which runs
//   two square roots and three divisions one bit a cycle, and by the shared
//   multiplier, used in turn for the squares, the stiffness scaling, the
//   direction products and the filter.
//   req_stall stays high while a tick is in work and while its result
//   waits for the output register; rsp_* holds steady while rsp_stall is high.
//   csr_* writes one register per cycle, csr_ready is always high; write
//   registers only while the block is idle.
//   reset (synchronous) marks all poses missing, clears the filter seed and
//   the output valid, and restores the register defaults.

module bimanual_virtual_coupling_force #(
   parameter int POS_WIDTH  = bvcf_pkg::POS_WIDTH_DEF,
   parameter int TIME_WIDTH = bvcf_pkg::TIME_WIDTH_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [bvcf_pkg::ACTION_W-1:0]        req_action,
   input  logic signed [POS_WIDTH-1:0]          req_pos_x,
   input  logic signed [POS_WIDTH-1:0]          req_pos_y,
   input  logic signed [POS_WIDTH-1:0]          req_pos_z,
   input  logic [TIME_WIDTH-1:0]                req_stamp_us,
   input  logic [TIME_WIDTH-1:0]                req_now_us,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [bvcf_pkg::FORCE_W-1:0]  rsp_left_force_x,
   output logic signed [bvcf_pkg::FORCE_W-1:0]  rsp_left_force_y,
   output logic signed [bvcf_pkg::FORCE_W-1:0]  rsp_left_force_z,
   output logic signed [bvcf_pkg::FORCE_W-1:0]  rsp_right_force_x,
   output logic signed [bvcf_pkg::FORCE_W-1:0]  rsp_right_force_y,
   output logic signed [bvcf_pkg::FORCE_W-1:0]  rsp_right_force_z,
   output logic [bvcf_pkg::STATUS_W-1:0]        rsp_status,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [bvcf_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [bvcf_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import bvcf_pkg::*;

   localparam int P    = POS_WIDTH;
   localparam int TW   = TIME_WIDTH;
   localparam int RW   = 3*P + TW;
   localparam int SW   = 2*P + 2;
   localparam int UW   = P + 3;
   localparam int RTW  = P + 1;
   localparam int MW   = (P + 1 > 33) ? P + 1 : 33;
   localparam int QW   = 31;
   localparam int CMAX = (P > QW) ? P : QW;
   localparam int CW   = $clog2(CMAX + 1);
   localparam logic [CW-1:0] SQ_LAST  = CW'(P);
   localparam logic [CW-1:0] DIV_LAST = CW'(QW - 1);

   typedef enum logic [21:0] {
      S_IDLE     = 22'b1 << 0,
      S_CHECK    = 22'b1 << 1,
      S_ST_RD    = 22'b1 << 2,
      S_ST_CMP   = 22'b1 << 3,
      S_SQ_LOAD  = 22'b1 << 4,
      S_SQ_DIFF  = 22'b1 << 5,
      S_SQ_MUL   = 22'b1 << 6,
      S_SQ_ACC   = 22'b1 << 7,
      S_DEGEN    = 22'b1 << 8,
      S_SQRT     = 22'b1 << 9,
      S_SQRT_END = 22'b1 << 10,
      S_EMAG     = 22'b1 << 11,
      S_FMUL     = 22'b1 << 12,
      S_FCLAMP   = 22'b1 << 13,
      S_QMUL     = 22'b1 << 14,
      S_DIV_INIT = 22'b1 << 15,
      S_DIV      = 22'b1 << 16,
      S_DIV_END  = 22'b1 << 17,
      S_E_DIFF   = 22'b1 << 18,
      S_E_MUL    = 22'b1 << 19,
      S_E_UPD    = 22'b1 << 20,
      S_DONE     = 22'b1 << 21
   } state_type;

   // configuration
   logic [31:0] stiff_ff;
   logic [30:0] deadband_ff;
   logic [30:0] limit_ff;
   logic [16:0] alpha_ff;
   logic [31:0] stale_lim_ff;

   // pose store
   logic [RW-1:0] pose_mem [4];
   logic [RW-1:0] rd_a_ff, rd_b_ff;
   logic [1:0]    rd_a_addr, rd_b_addr;
   logic [3:0]    pose_valid_ff, pose_valid_in;
   logic          pose_we;
   logic [TW-1:0] pose_time;

   // sequencer and datapath
   state_type       state_ff, state_in;
   logic [CW-1:0]   cnt_ff, cnt_in;
   logic [1:0]      comp_ff, comp_in;
   logic            pair_ff, pair_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic            stale_ff, stale_in;
   logic            eneg_ff, eneg_in;
   logic [TW-1:0]   now_ff, now_in;
   logic [SW-1:0]   acc_ff, acc_in;
   logic [SW-1:0]   sm_ff, sm_in;
   logic [SW-1:0]   ss_ff, ss_in;
   logic [P-1:0]    diff_ff, diff_in;
   logic [P-1:0]    ds_ff [3];
   logic [P-1:0]    ds_in [3];
   logic            ns_ff [3];
   logic            ns_in [3];
   logic [UW-1:0]   rem_ff, rem_in;
   logic [RTW-1:0]  root_ff, root_in;
   logic [SW-1:0]   n_ff, n_in;
   logic [QW-1:0]   q_ff, q_in;
   logic [RTW-1:0]  dm_ff, dm_in;
   logic [RTW-1:0]  dsd_ff, dsd_in;
   logic [RTW-1:0]  emag_ff, emag_in;
   logic [30:0]     fmag_ff, fmag_in;
   logic [31:0]     f_ff [3];
   logic [31:0]     f_in [3];
   logic [31:0]     filt_ff [3];
   logic [31:0]     filt_in [3];
   logic            seeded_ff, seeded_in;
   logic [32:0]     ed_mag_ff, ed_mag_in;
   logic            ed_neg_ff, ed_neg_in;

   // shared multiplier
   logic [MW-1:0]   mul_a, mul_b;
   logic [2*MW-1:0] prod_ff;

   // shared subtract unit
   logic [UW-1:0]   sub_a, sub_b;
   logic [UW:0]     sub_res;
   logic            sub_ge;

   // output register
   logic            rsp_valid_ff, rsp_valid_in;
   logic [31:0]     out_l_ff [3];
   logic [31:0]     out_l_in [3];
   logic [31:0]     out_r_ff [3];
   logic [31:0]     out_r_in [3];
   logic [STATUS_W-1:0] out_st_ff, out_st_in;

   // helpers
   logic            req_take;
   logic [16:0]     alpha_eff;
   logic [P-1:0]    coord_a, coord_b;
   logic [P:0]      pd;
   logic [P-1:0]    pd_mag;
   logic [TW-1:0]   t_pose;
   logic [TW-1:0]   age;
   logic [RTW-1:0]  emag_raw;
   logic            dist_lt;
   logic [32:0]     ed;
   logic [48:0]     rnd_sum;
   logic [32:0]     qv;

   assign csr_ready = 1'b1;
   assign req_stall = (state_ff != S_IDLE);
   assign req_take  = req_valid && !req_stall;

   assign alpha_eff = (alpha_ff > ALPHA_ONE) ? ALPHA_ONE : alpha_ff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         stiff_ff     <= STIFFNESS_RST;
         deadband_ff  <= DEADBAND_RST;
         limit_ff     <= LIMIT_RST;
         alpha_ff     <= ALPHA_RST;
         stale_lim_ff <= STALE_RST;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_STIFFNESS: stiff_ff     <= csr_wdata;
            CSR_DEADBAND:  deadband_ff  <= csr_wdata[30:0];
            CSR_LIMIT:     limit_ff     <= csr_wdata[30:0];
            CSR_ALPHA:     alpha_ff     <= csr_wdata[16:0];
            CSR_STALE:     stale_lim_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // pose store: one row per pose, {time, z, y, x}
   assign pose_we   = req_take && !req_action[ACTION_W-1];
   assign pose_time = (req_stamp_us != '0) ? req_stamp_us : req_now_us;
   assign rd_a_addr = (state_ff == S_ST_RD || state_ff == S_ST_CMP) ? cnt_ff[1:0]
                                                                     : {pair_ff, 1'b1};
   assign rd_b_addr = {pair_ff, 1'b0};

   always_ff @(posedge clock) begin
      if (pose_we) begin
         pose_mem[req_action[1:0]] <= {pose_time, req_pos_z, req_pos_y, req_pos_x};
      end
      rd_a_ff <= pose_mem[rd_a_addr];
      rd_b_ff <= pose_mem[rd_b_addr];
   end

   // shared multiplier, registered product
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (1'b1)
         state_ff == S_SQ_MUL: begin
            mul_a = MW'(diff_ff);
            mul_b = MW'(diff_ff);
         end
         state_ff == S_FMUL: begin
            mul_a = MW'(stiff_ff);
            mul_b = MW'(emag_ff);
         end
         state_ff == S_QMUL: begin
            mul_a = MW'(fmag_ff);
            mul_b = MW'(ds_ff[comp_ff]);
         end
         state_ff == S_E_MUL: begin
            mul_a = MW'(alpha_eff);
            mul_b = MW'(ed_mag_ff);
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
   end

   // shared subtract unit: square root and division steps
   always_comb begin
      if (state_ff == S_DIV) begin
         sub_a = {rem_ff[UW-2:0], n_ff[SW-1]};
         sub_b = UW'(dsd_ff);
      end else begin
         sub_a = {rem_ff[UW-3:0], n_ff[SW-1:SW-2]};
         sub_b = UW'({root_ff[RTW-2:0], 2'b01});
      end
   end

   assign sub_res = {1'b0, sub_a} - {1'b0, sub_b};
   assign sub_ge  = !sub_res[UW];

   // datapath helpers
   assign coord_a  = rd_a_ff[32'(comp_ff)*P +: P];
   assign coord_b  = rd_b_ff[32'(comp_ff)*P +: P];
   assign pd       = {coord_a[P-1], coord_a} - {coord_b[P-1], coord_b};
   assign pd_mag   = pd[P] ? P'(-pd) : pd[P-1:0];
   assign t_pose   = rd_a_ff[RW-1:3*P];
   assign age      = now_ff - t_pose;
   assign dist_lt  = dsd_ff < dm_ff;
   assign emag_raw = dist_lt ? (dm_ff - dsd_ff) : (dsd_ff - dm_ff);
   assign ed       = {f_ff[comp_ff][31], f_ff[comp_ff]} - {filt_ff[comp_ff][31], filt_ff[comp_ff]};
   assign rnd_sum  = prod_ff[48:0] + (ed_neg_ff ? 49'd32767 : 49'd32768);
   assign qv       = {2'b00, q_ff};

   // sequencer
   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      comp_in       = comp_ff;
      pair_in       = pair_ff;
      status_in     = status_ff;
      stale_in      = stale_ff;
      eneg_in       = eneg_ff;
      now_in        = now_ff;
      acc_in        = acc_ff;
      sm_in         = sm_ff;
      ss_in         = ss_ff;
      diff_in       = diff_ff;
      ds_in         = ds_ff;
      ns_in         = ns_ff;
      rem_in        = rem_ff;
      root_in       = root_ff;
      n_in          = n_ff;
      q_in          = q_ff;
      dm_in         = dm_ff;
      dsd_in        = dsd_ff;
      emag_in       = emag_ff;
      fmag_in       = fmag_ff;
      f_in          = f_ff;
      filt_in       = filt_ff;
      seeded_in     = seeded_ff;
      ed_mag_in     = ed_mag_ff;
      ed_neg_in     = ed_neg_ff;
      pose_valid_in = pose_valid_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      out_l_in      = out_l_ff;
      out_r_in      = out_r_ff;
      out_st_in     = out_st_ff;

      if (pose_we) begin
         pose_valid_in[req_action[1:0]] = 1'b1;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_take && req_action == ACT_TICK) begin
               now_in   = req_now_us;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (pose_valid_ff != 4'hf) begin
               status_in = STAT_MISSING;
               state_in  = S_DONE;
            end else begin
               cnt_in   = '0;
               stale_in = 1'b0;
               state_in = S_ST_RD;
            end
         end
         S_ST_RD: begin
            state_in = S_ST_CMP;
         end
         S_ST_CMP: begin
            if (now_ff > t_pose && age > TW'(stale_lim_ff)) begin
               stale_in = 1'b1;
            end
            if (cnt_ff[1:0] == 2'd3) begin
               if (stale_in) begin
                  status_in = STAT_STALE;
                  state_in  = S_DONE;
               end else begin
                  pair_in  = 1'b0;
                  comp_in  = '0;
                  acc_in   = '0;
                  state_in = S_SQ_LOAD;
               end
            end else begin
               cnt_in   = cnt_ff + 1'b1;
               state_in = S_ST_RD;
            end
         end
         S_SQ_LOAD: begin
            state_in = S_SQ_DIFF;
         end
         S_SQ_DIFF: begin
            diff_in = pd_mag;
            if (pair_ff) begin
               ds_in[comp_ff] = pd_mag;
               ns_in[comp_ff] = pd[P];
            end
            state_in = S_SQ_MUL;
         end
         S_SQ_MUL: begin
            state_in = S_SQ_ACC;
         end
         S_SQ_ACC: begin
            acc_in = acc_ff + SW'(prod_ff[2*P-1:0]);
            if (comp_ff == 2'd2) begin
               comp_in = '0;
               if (!pair_ff) begin
                  sm_in    = acc_in;
                  acc_in   = '0;
                  pair_in  = 1'b1;
                  state_in = S_SQ_LOAD;
               end else begin
                  ss_in    = acc_in;
                  state_in = S_DEGEN;
               end
            end else begin
               comp_in  = comp_ff + 1'b1;
               state_in = S_SQ_DIFF;
            end
         end
         S_DEGEN: begin
            if (sm_ff <= SW'(1) || ss_ff <= SW'(1)) begin
               status_in = STAT_DEGEN;
               state_in  = S_DONE;
            end else begin
               n_in     = sm_ff;
               rem_in   = '0;
               root_in  = '0;
               cnt_in   = '0;
               pair_in  = 1'b0;
               state_in = S_SQRT;
            end
         end
         S_SQRT: begin
            if (sub_ge) begin
               rem_in  = sub_res[UW-1:0];
               root_in = {root_ff[RTW-2:0], 1'b1};
            end else begin
               rem_in  = sub_a;
               root_in = {root_ff[RTW-2:0], 1'b0};
            end
            n_in = {n_ff[SW-3:0], 2'b00};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == SQ_LAST) begin
               state_in = S_SQRT_END;
            end
         end
         S_SQRT_END: begin
            if (!pair_ff) begin
               dm_in    = root_ff;
               n_in     = ss_ff;
               rem_in   = '0;
               root_in  = '0;
               cnt_in   = '0;
               pair_in  = 1'b1;
               state_in = S_SQRT;
            end else begin
               dsd_in   = root_ff;
               state_in = S_EMAG;
            end
         end
         S_EMAG: begin
            eneg_in  = dist_lt;
            emag_in  = (MW'(emag_raw) < MW'(deadband_ff)) ? '0 : emag_raw;
            state_in = S_FMUL;
         end
         S_FMUL: begin
            state_in = S_FCLAMP;
         end
         S_FCLAMP: begin
            if ((|prod_ff[2*MW-1:51]) || prod_ff[50:20] > limit_ff) begin
               fmag_in = limit_ff;
            end else begin
               fmag_in = prod_ff[50:20];
            end
            comp_in  = '0;
            state_in = S_QMUL;
         end
         S_QMUL: begin
            state_in = S_DIV_INIT;
         end
         S_DIV_INIT: begin
            rem_in   = UW'(prod_ff[P+QW-1:QW]);
            n_in     = {prod_ff[QW-1:0], {(SW-QW){1'b0}}};
            q_in     = '0;
            cnt_in   = '0;
            state_in = S_DIV;
         end
         S_DIV: begin
            if (sub_ge) begin
               rem_in = sub_res[UW-1:0];
               q_in   = {q_ff[QW-2:0], 1'b1};
            end else begin
               rem_in = sub_a;
               q_in   = {q_ff[QW-2:0], 1'b0};
            end
            n_in   = {n_ff[SW-2:0], 1'b0};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == DIV_LAST) begin
               state_in = S_DIV_END;
            end
         end
         S_DIV_END: begin
            f_in[comp_ff] = (eneg_ff != ns_ff[comp_ff]) ? (32'd0 - qv[31:0]) : qv[31:0];
            if (comp_ff == 2'd2) begin
               comp_in  = '0;
               state_in = S_E_DIFF;
            end else begin
               comp_in  = comp_ff + 1'b1;
               state_in = S_QMUL;
            end
         end
         S_E_DIFF: begin
            if (!seeded_ff || alpha_eff == '0) begin
               filt_in[comp_ff] = f_ff[comp_ff];
               if (comp_ff == 2'd2) begin
                  seeded_in = 1'b1;
                  status_in = STAT_OK;
                  state_in  = S_DONE;
               end else begin
                  comp_in = comp_ff + 1'b1;
               end
            end else begin
               ed_neg_in = ed[32];
               ed_mag_in = ed[32] ? -ed : ed;
               state_in  = S_E_MUL;
            end
         end
         S_E_MUL: begin
            state_in = S_E_UPD;
         end
         S_E_UPD: begin
            filt_in[comp_ff] = ed_neg_ff ? filt_ff[comp_ff] - rnd_sum[47:16]
                                         : filt_ff[comp_ff] + rnd_sum[47:16];
            if (comp_ff == 2'd2) begin
               seeded_in = 1'b1;
               status_in = STAT_OK;
               state_in  = S_DONE;
            end else begin
               comp_in  = comp_ff + 1'b1;
               state_in = S_E_DIFF;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               out_st_in    = status_ff;
               for (int i = 0; i < 3; i++) begin
                  out_l_in[i] = (status_ff == STAT_OK) ? filt_ff[i] : '0;
                  out_r_in[i] = (status_ff == STAT_OK) ? (32'd0 - filt_ff[i]) : '0;
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         pose_valid_ff <= '0;
         seeded_ff     <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         for (int i = 0; i < 3; i++) begin
            filt_ff[i] <= '0;
         end
      end else begin
         state_ff      <= state_in;
         pose_valid_ff <= pose_valid_in;
         seeded_ff     <= seeded_in;
         rsp_valid_ff  <= rsp_valid_in;
         filt_ff       <= filt_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff    <= cnt_in;
      comp_ff   <= comp_in;
      pair_ff   <= pair_in;
      status_ff <= status_in;
      stale_ff  <= stale_in;
      eneg_ff   <= eneg_in;
      now_ff    <= now_in;
      acc_ff    <= acc_in;
      sm_ff     <= sm_in;
      ss_ff     <= ss_in;
      diff_ff   <= diff_in;
      ds_ff     <= ds_in;
      ns_ff     <= ns_in;
      rem_ff    <= rem_in;
      root_ff   <= root_in;
      n_ff      <= n_in;
      q_ff      <= q_in;
      dm_ff     <= dm_in;
      dsd_ff    <= dsd_in;
      emag_ff   <= emag_in;
      fmag_ff   <= fmag_in;
      f_ff      <= f_in;
      ed_mag_ff <= ed_mag_in;
      ed_neg_ff <= ed_neg_in;
      out_l_ff  <= out_l_in;
      out_r_ff  <= out_r_in;
      out_st_ff <= out_st_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_left_force_x  = out_l_ff[0];
   assign rsp_left_force_y  = out_l_ff[1];
   assign rsp_left_force_z  = out_l_ff[2];
   assign rsp_right_force_x = out_r_ff[0];
   assign rsp_right_force_y = out_r_ff[1];
   assign rsp_right_force_z = out_r_ff[2];
   assign rsp_status        = out_st_ff;

endmodule

### hw/rtl/bvcf_checker.sv
// port checker for the bimanual virtual coupling force block
// depends on bvcf_pkg; bound to the top level below

module bvcf_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_valid,
   input logic                                 req_stall,
   input logic [bvcf_pkg::ACTION_W-1:0]        req_action,
   input logic                                 rsp_valid,
   input logic                                 rsp_stall,
   input logic signed [bvcf_pkg::FORCE_W-1:0]  rsp_left_force_x,
   input logic signed [bvcf_pkg::FORCE_W-1:0]  rsp_left_force_y,
   input logic signed [bvcf_pkg::FORCE_W-1:0]  rsp_left_force_z,
   input logic signed [bvcf_pkg::FORCE_W-1:0]  rsp_right_force_x,
   input logic signed [bvcf_pkg::FORCE_W-1:0]  rsp_right_force_y,
   input logic signed [bvcf_pkg::FORCE_W-1:0]  rsp_right_force_z,
   input logic [bvcf_pkg::STATUS_W-1:0]        rsp_status
);
   import bvcf_pkg::*;

   logic pose_in;
   assign pose_in = req_valid && !req_stall && req_action != ACT_TICK;

   // a stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_left_force_x)
         && $stable(rsp_status))
      else $error("result word changed while stalled");

   // error status gives zero force
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STAT_OK |-> rsp_left_force_x == '0
         && rsp_left_force_y == '0 && rsp_left_force_z == '0)
      else $error("nonzero force with error status");

   // right force mirrors left force
   a_mirror: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_right_force_x == -rsp_left_force_x
         && rsp_right_force_y == -rsp_left_force_y
         && rsp_right_force_z == -rsp_left_force_z)
      else $error("right force is not the negated left force");

   // a pose word never starts a computation
   a_pose_fast: assert property (@(posedge clock) disable iff (reset)
      pose_in |=> !req_stall)
      else $error("block busy after a pose word");

endmodule

bind bimanual_virtual_coupling_force bvcf_checker u_bvcf_checker (.*);

### test/bimanual_virtual_coupling_force_tb.sv
// testbench for bimanual_virtual_coupling_force: pose and tick words with random content,
// a scoreboard that predicts each force word, randomized idling; depends on bvcf_pkg
`timescale 1ns / 100ps

module bimanual_virtual_coupling_force_tb;
   import bvcf_pkg::*;

   localparam int LIMIT_CYCLES = 3000000;
   localparam int SETTLE = 250;

   typedef struct {
      logic [2:0]         action;
      logic signed [31:0] x, y, z;
      logic [47:0]        stamp, now;
   } pose_word_t;

   typedef struct {
      logic [31:0] lx, ly, lz, rx, ry, rz;
      logic [1:0]  status;
   } force_word_t;

   class force_scoreboard;
      logic [31:0]        stiffness;
      logic [30:0]        deadband;
      logic [30:0]        limit;
      logic [16:0]        alpha;
      logic [31:0]        stale_lim;
      logic [3:0]         have_pose;
      logic signed [31:0] coord[4][3];
      logic [47:0]        pose_time[4];
      bit                 seeded;
      longint             filt[3];
      force_word_t        expected_q[$];
      int                 errors, words, results;
      int                 by_status[4];

      function new();
         stiffness = STIFFNESS_RST;
         deadband = DEADBAND_RST;
         limit = LIMIT_RST;
         alpha = ALPHA_RST;
         stale_lim = STALE_RST;
         have_pose = '0;
         seeded = 0;
         for (int i = 0; i < 4; i++) begin
            pose_time[i] = '0;
            for (int j = 0; j < 3; j++) coord[i][j] = '0;
         end
         for (int j = 0; j < 3; j++) filt[j] = 0;
      endfunction

      function void set_reg(csr_index_type idx, logic [31:0] val);
         case (idx)
            CSR_STIFFNESS: stiffness = val;
            CSR_DEADBAND: deadband = val[30:0];
            CSR_LIMIT: limit = val[30:0];
            CSR_ALPHA: alpha = val[16:0];
            CSR_STALE: stale_lim = val;
            default: ;
         endcase
      endfunction

      function logic [63:0] isqrt(logic [127:0] n);
         logic [63:0] res, c;
         res = '0;
         for (int b = 63; b >= 0; b--) begin
            c = res | (64'd1 << b);
            if (128'(c) * 128'(c) <= n) res = c;
         end
         return res;
      endfunction

      function longint round16(longint v);
         longint m;
         if (v >= 0) return (v + 32768) >>> 16;
         m = -v;
         if (m <= 32768) return 0;
         return -((m - 32768 + 65535) >>> 16);
      endfunction

      function void note_word(pose_word_t w);
         force_word_t r;
         logic [63:0]  dm_mag, ds_mag[3], dist_m, dist_s, emag, fmag;
         logic [127:0] sm, ss, p, q;
         longint       d, f[3];
         bit           eneg, ns[3];
         logic [16:0]  a_eff;
         words++;
         if (w.action < ACT_TICK) begin
            coord[w.action][0] = w.x;
            coord[w.action][1] = w.y;
            coord[w.action][2] = w.z;
            pose_time[w.action] = (w.stamp != 0) ? w.stamp : w.now;
            have_pose[w.action] = 1'b1;
            return;
         end
         if (w.action != ACT_TICK) return;
         r = '{default: '0};
         r.status = STAT_OK;
         if (have_pose != 4'hf) r.status = STAT_MISSING;
         else
            for (int i = 0; i < 4; i++)
               if (w.now > pose_time[i] && w.now - pose_time[i] > 48'(stale_lim))
                  r.status = STAT_STALE;
         if (r.status == STAT_OK) begin
            sm = '0;
            ss = '0;
            for (int i = 0; i < 3; i++) begin
               d = longint'(coord[ACT_MASTER_RIGHT][i]) - longint'(coord[ACT_MASTER_LEFT][i]);
               dm_mag = (d < 0) ? -d : d;
               d = longint'(coord[ACT_SLAVE_RIGHT][i]) - longint'(coord[ACT_SLAVE_LEFT][i]);
               ns[i] = d < 0;
               ds_mag[i] = (d < 0) ? -d : d;
               sm += 128'(dm_mag) * 128'(dm_mag);
               ss += 128'(ds_mag[i]) * 128'(ds_mag[i]);
            end
            if (sm <= 1 || ss <= 1) r.status = STAT_DEGEN;
            else begin
               dist_m = isqrt(sm);
               dist_s = isqrt(ss);
               eneg = dist_s < dist_m;
               emag = eneg ? dist_m - dist_s : dist_s - dist_m;
               if (emag < 64'(deadband)) emag = 0;
               p = (128'(stiffness) * 128'(emag)) >> 20;
               fmag = (p > 128'(limit)) ? 64'(limit) : p[63:0];
               for (int i = 0; i < 3; i++) begin
                  q = (128'(fmag) * 128'(ds_mag[i])) / 128'(dist_s);
                  f[i] = (eneg != ns[i]) ? -longint'(q[63:0]) : longint'(q[63:0]);
               end
               a_eff = (alpha > ALPHA_ONE) ? ALPHA_ONE : alpha;
               for (int i = 0; i < 3; i++)
                  if (!seeded || a_eff == 0) filt[i] = f[i];
                  else filt[i] += round16(longint'(a_eff) * (f[i] - filt[i]));
               seeded = 1;
               r.lx = filt[0][31:0];
               r.ly = filt[1][31:0];
               r.lz = filt[2][31:0];
               r.rx = 32'(-filt[0]);
               r.ry = 32'(-filt[1]);
               r.rz = 32'(-filt[2]);
            end
         end
         expected_q.push_back(r);
      endfunction

      task report(string what, logic [31:0] got, logic [31:0] want);
         $display("mismatch on %s: got %h, expected %h (result %0d)", what, got, want, results);
         errors++;
      endtask

      task check_word(force_word_t g);
         force_word_t e;
         results++;
         by_status[g.status]++;
         if (expected_q.size() == 0) begin
            $display("unexpected force word, status %0d", g.status);
            errors++;
            return;
         end
         e = expected_q.pop_front();
         if (g.lx !== e.lx) report("left_force_x", g.lx, e.lx);
         if (g.ly !== e.ly) report("left_force_y", g.ly, e.ly);
         if (g.lz !== e.lz) report("left_force_z", g.lz, e.lz);
         if (g.rx !== e.rx) report("right_force_x", g.rx, e.rx);
         if (g.ry !== e.ry) report("right_force_y", g.ry, e.ry);
         if (g.rz !== e.rz) report("right_force_z", g.rz, e.rz);
         if (g.status !== e.status) report("status", 32'(g.status), 32'(e.status));
      endtask
   endclass

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_stall;
   logic [2:0] req_action = '0;
   logic signed [31:0] req_pos_x = '0, req_pos_y = '0, req_pos_z = '0;
   logic [47:0] req_stamp_us = '0, req_now_us = '0;
   logic rsp_valid;
   logic rsp_stall = 0;
   logic signed [31:0] rsp_left_force_x, rsp_left_force_y, rsp_left_force_z;
   logic signed [31:0] rsp_right_force_x, rsp_right_force_y, rsp_right_force_z;
   logic [1:0] rsp_status;
   logic csr_valid = 0;
   logic csr_ready;
   logic [2:0] csr_index = '0;
   logic [31:0] csr_wdata = '0;

   force_scoreboard sb = new();
   int snd_idle, rcv_idle;
   int hold_left;
   bit hold_request;
   int cycles;
   logic [47:0] now_us;

   bimanual_virtual_coupling_force uut (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > LIMIT_CYCLES) begin
         $display("timeout after %0d cycles", cycles);
         $display("FAIL");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall)
         sb.note_word('{req_action, req_pos_x, req_pos_y, req_pos_z, req_stamp_us, req_now_us});
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_word('{rsp_left_force_x, rsp_left_force_y, rsp_left_force_z,
                         rsp_right_force_x, rsp_right_force_y, rsp_right_force_z, rsp_status});
   end

   // receiver stalls, with one long hold-off on request
   always @(posedge clock) begin
      if (hold_request) begin
         hold_request = 0;
         hold_left = 3000;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < rcv_idle);
      end
   end

   task send(logic [2:0] act, logic [31:0] x, logic [31:0] y, logic [31:0] z,
             logic [47:0] stamp, logic [47:0] now);
      req_valid <= 1'b1;
      req_action <= act;
      req_pos_x <= x;
      req_pos_y <= y;
      req_pos_z <= z;
      req_stamp_us <= stamp;
      req_now_us <= now;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if ($urandom_range(99) < snd_idle) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   task write_regs(logic [31:0] stiff, logic [31:0] dead, logic [31:0] lim,
                   logic [31:0] alp, logic [31:0] stale);
      logic [31:0] vals[5];
      vals = '{stiff, dead, lim, alp, stale};
      for (int i = 0; i < 5; i++) begin
         csr_valid <= 1'b1;
         csr_index <= 3'(i);
         csr_wdata <= vals[i];
         @(posedge clock);
         while (!csr_ready) @(posedge clock);
         sb.set_reg(csr_index_type'(i), vals[i]);
      end
      csr_valid <= 1'b0;
   endtask

   task drain;
      req_valid <= 1'b0;
      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   function logic [47:0] rand48();
      return {16'($urandom), 32'($urandom)};
   endfunction

   function logic [31:0] rand_coord(logic signed [31:0] center);
      if ($urandom_range(19) == 0) return $urandom;
      if ($urandom_range(3) == 0) return center + $signed(32'($urandom_range(8191))) - 4096;
      return center + $signed(32'($urandom_range(4194303))) - 2097152;
   endfunction

   function logic [47:0] rand_stamp();
      int r;
      r = $urandom_range(99);
      if (r < 30) return '0;
      if (r < 85) return (now_us > 250000) ? now_us - $urandom_range(250000) : now_us;
      if (r < 95) return now_us + $urandom_range(1, 1000);
      return rand48();
   endfunction

   task run_random(int n);
      int sent, base;
      logic signed [31:0] cx, cy, cz;
      sent = 0;
      while (sent < n) begin
         now_us += $urandom_range(40000);
         if ($urandom_range(29) == 0) now_us += 300000;
         if ($urandom_range(99) < 80) begin
            base = $urandom_range(3);
            cx = $signed(32'($urandom_range(268435455))) - 134217728;
            cy = $signed(32'($urandom_range(268435455))) - 134217728;
            cz = $signed(32'($urandom_range(268435455))) - 134217728;
            for (int k = 0; k < 4; k++)
               if ($urandom_range(9) != 0) begin
                  send(3'((base + k) % 4), rand_coord(cx), rand_coord(cy), rand_coord(cz),
                       rand_stamp(), now_us);
                  sent++;
               end
            repeat ($urandom_range(1, 3)) begin
               send(ACT_TICK, $urandom, $urandom, $urandom, rand48(), now_us);
               now_us += $urandom_range(20000);
               sent++;
            end
         end else begin
            base = $urandom_range(7);
            send(3'(base), $urandom, $urandom, $urandom, rand48(),
                 ($urandom_range(3) == 0) ? rand48() : now_us);
            if (base <= ACT_TICK) sent++;
         end
      end
      drain();
   endtask

   initial begin
      snd_idle = 23;
      rcv_idle = 85;
      now_us = 48'd1000;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: missing, extremes, ok, stale, degenerate, unknown actions
      send(ACT_TICK, 0, 0, 0, 0, 1000);
      send(ACT_MASTER_LEFT, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, 1000);
      send(ACT_TICK, 0, 0, 0, 0, 1000);
      send(ACT_MASTER_RIGHT, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 1000, 1000);
      send(ACT_SLAVE_LEFT, 32'h0010_0000, 32'hfff0_0000, 0, 1200, 1000);
      send(ACT_SLAVE_RIGHT, 32'h0030_0000, 32'h0010_0000, 32'h0008_0000, 48'hffff_ffff_ffff,
           1000);
      send(ACT_TICK, 0, 0, 0, 0, 2000);
      send(ACT_MASTER_LEFT, 32'h0010_0000, 0, 0, 0, 2000);
      send(ACT_MASTER_RIGHT, 32'h0011_0000, 0, 0, 0, 2000);
      send(ACT_TICK, 0, 0, 0, 0, 3000);
      send(ACT_TICK, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 48'hffff_ffff_ffff, 3000);
      send(ACT_TICK, 0, 0, 0, 0, 1000 + 201001);
      send(ACT_MASTER_RIGHT, 32'h0010_0001, 0, 0, 0, 3000);
      send(ACT_TICK, 0, 0, 0, 0, 3000);
      send(ACT_MASTER_RIGHT, 32'h0010_0000, 0, 0, 0, 3000);
      send(ACT_TICK, 0, 0, 0, 0, 3000);
      send(3'd5, 1, 2, 3, 4, 5);
      send(3'd6, 32'hffff_ffff, 0, 0, 0, 0);
      send(3'd7, 0, 0, 0, 48'hffff_ffff_ffff, 48'hffff_ffff_ffff);
      send(ACT_TICK, 0, 0, 0, 0, 48'hffff_ffff_ffff);
      drain();
      now_us = 48'd500000;

      run_random(320);

      snd_idle = 85;
      rcv_idle = 23;
      write_regs(32'hffff_ffff, 0, 32'h7fff_ffff, 0, 32'hffff_ffff);
      run_random(320);
      write_regs(32'h0200_0000, 32'h7fff_ffff, 0, 32'h0001_ffff, 0);
      run_random(100);

      snd_idle = 0;
      rcv_idle = 0;
      write_regs(32'h0064_0000, 4096, 32'h0100_0000, 32'h0001_0000, 100000);
      hold_request = 1;
      run_random(320);
      write_regs(0, 0, 32'h0001_0000, 1, 300000);
      run_random(240);

      $display("covered %0d words and %0d force words over five register settings",
               sb.words, sb.results);
      $display("status seen: ok %0d, missing %0d, stale %0d, degenerate %0d",
               sb.by_status[0], sb.by_status[1], sb.by_status[2], sb.by_status[3]);
      if (sb.errors == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
